>>> rtl/sorted_table_binary_search_macros.svh
// ----------------------------------------------------------------------------
// sorted_table_binary_search_macros.svh
// assertion helpers for the checker file, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// same-cycle implication
`define STBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stbs assertion failed");

// next-cycle implication
`define STBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stbs assertion failed");

`endif

>>> rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// types and constants of the sorted table binary search block
// ----------------------------------------------------------------------------
package stbs_pkg;

    // table size and derived widths
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // fixed field widths
    localparam int SLOT_W      = 10;
    localparam int VALUE_W     = 64;
    localparam int COUNT_W     = 11;
    localparam int INDEX_W     = 10;

    // operation codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // input item
    typedef struct packed {
        logic                      func;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] item_value;
    } stbs_in_t;

    // result item
    typedef struct packed {
        logic               hit;
        logic [INDEX_W-1:0] hit_index;
    } stbs_out_t;

    // outcome of one probe
    typedef struct packed {
        logic             found;
        logic             exhausted;
        logic [CNT_W-1:0] low_next;
        logic [CNT_W-1:0] high_next;
    } stbs_probe_t;

    // search sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_FINISH
    } stbs_state_t;

endpackage

>>> rtl/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/stbs_probe.sv
// ----------------------------------------------------------------------------
// stbs_probe
// shared compare unit: checks one probed entry and narrows the search range
// ----------------------------------------------------------------------------
module stbs_probe
    import stbs_pkg::*;
(
    input  logic signed [VALUE_W-1:0] entry,
    input  logic signed [VALUE_W-1:0] key,
    input  logic [CNT_W-1:0]          low,
    input  logic [CNT_W-1:0]          high,
    input  logic [ADDR_W-1:0]         mid,
    output stbs_probe_t               outcome
);

    logic             is_eq;
    logic             is_lt;
    logic [CNT_W-1:0] mid_ext;

    assign is_eq   = (entry == key);
    assign is_lt   = (entry < key);
    assign mid_ext = CNT_W'(mid);

    // range update: below the key moves low past mid, above it pulls high to mid
    always_comb
    begin
        outcome.found     = is_eq;
        outcome.low_next  = low;
        outcome.high_next = high;
        if (!is_eq)
        begin
            if (is_lt)
            begin
                outcome.low_next = mid_ext + CNT_W'(1);
            end
            else
            begin
                outcome.high_next = mid_ext;
            end
        end
        outcome.exhausted = !is_eq && (outcome.low_next >= outcome.high_next);
    end

endmodule

>>> rtl/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// table of signed 64-bit entries with a binary search over the entries in use
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  stbs_in_t  (func, slot, item_value)
//   out      output     out_valid/out_stall  stbs_out_t (hit, hit_index)
//   cfg      input      cfg_valid/cfg_ready  entry_count, 11 bits
//
// a write is taken in ST_IDLE; a search passes ST_PROBE and ST_COMPARE once per
// probe, then ST_FINISH: each probe is a registered table read followed
// by one pass through the shared compare unit
// in_stall stays high from a search transfer until its result is in the
// output register; a stalled result holds there while new items are taken
// reset clears the sequencer, the output valid flag and entry_count; the table
// contents are not cleared
// ----------------------------------------------------------------------------
module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  stbs_in_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output stbs_out_t          out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    stbs_state_t state_reg, state_next;

    logic [COUNT_W-1:0]        entry_count_reg;
    logic [CNT_W-1:0]          low_reg, low_next;
    logic [CNT_W-1:0]          high_reg, high_next;
    logic [ADDR_W-1:0]         mid_reg, mid_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    stbs_out_t                 result_reg, result_next;
    logic                      out_valid_reg, out_valid_next;
    stbs_out_t                 out_data_reg, out_data_next;

    logic                      in_xfer;
    logic                      write_xfer;
    logic                      search_xfer;
    logic                      out_free;
    logic                      out_load;
    logic                      ram_we;
    logic                      ram_rd;
    logic [CNT_W-1:0]          count_eff;
    logic [CNT_W-1:0]          mid_calc;
    logic [VALUE_W-1:0]        ram_rd_data;
    stbs_probe_t               outcome;

    // handshake decode
    assign in_xfer     = in_valid && !in_stall;
    assign write_xfer  = in_xfer && (in_data.func == FUNC_WRITE);
    assign search_xfer = in_xfer && (in_data.func == FUNC_SEARCH);
    assign out_free    = !out_valid_reg || !out_stall;
    assign cfg_ready   = 1'b1;

    // entries in use, saturated at the table size
    assign count_eff = (32'(entry_count_reg) > TABLE_DEPTH)
                       ? CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_reg);

    // midpoint of the open range [low, high)
    assign mid_calc = low_reg + ((high_reg - low_reg - CNT_W'(1)) >> 1);

    // table storage
    stbs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ADDR_W'(in_data.slot)),
        .wr_data (in_data.item_value),
        .rd_en   (ram_rd),
        .rd_addr (mid_reg),
        .rd_data (ram_rd_data)
    );

    // compare unit
    stbs_probe u_probe (
        .entry   ($signed(ram_rd_data)),
        .key     (key_reg),
        .low     (low_reg),
        .high    (high_reg),
        .mid     (mid_reg),
        .outcome (outcome)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (search_xfer)
                begin
                    state_next = (count_eff == '0) ? ST_FINISH : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (outcome.found || outcome.exhausted)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        ram_we   = 1'b0;
        ram_rd   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                ram_we   = write_xfer && (32'(in_data.slot) < TABLE_DEPTH);
            end
            ST_PROBE:
            begin
                ram_rd = 1'b1;
            end
            ST_COMPARE:
            begin
                ram_rd = 1'b0;
            end
            ST_FINISH:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // search datapath
    always_comb
    begin
        low_next    = low_reg;
        high_next   = high_reg;
        mid_next    = mid_reg;
        key_next    = key_reg;
        result_next = result_reg;
        if (search_xfer)
        begin
            low_next    = '0;
            high_next   = count_eff;
            key_next    = in_data.item_value;
            result_next = '0;
        end
        else if (state_reg == ST_PROBE)
        begin
            mid_next = ADDR_W'(mid_calc);
        end
        else if (state_reg == ST_COMPARE)
        begin
            low_next  = outcome.low_next;
            high_next = outcome.high_next;
            if (outcome.found)
            begin
                result_next.hit       = 1'b1;
                result_next.hit_index = INDEX_W'(mid_reg);
            end
        end
    end

    // the probe address must be valid in the same cycle as ST_PROBE's read
    // so mid is registered on the way into ST_PROBE
    logic [ADDR_W-1:0] mid_issue;
    assign mid_issue = ADDR_W'(mid_calc);

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                entry_count_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        low_reg      <= low_next;
        high_reg     <= high_next;
        key_reg      <= key_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
        if (state_next == ST_PROBE)
        begin
            mid_reg <= (search_xfer) ? '0 + ADDR_W'((count_eff - CNT_W'(1)) >> 1)
                                     : ADDR_W'(
                                           outcome.low_next
                                           + ((outcome.high_next - outcome.low_next
                                               - CNT_W'(1)) >> 1));
        end
        else
        begin
            mid_reg <= (state_reg == ST_PROBE) ? mid_issue : mid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker
// port-level checks of the sorted table binary search block, bound to the top
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_macros.svh"

module stbs_checker
    import stbs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input stbs_in_t           in_data,
    input logic               out_valid,
    input logic               out_stall,
    input stbs_out_t          out_data
);

    logic search_xfer;
    logic write_xfer;

    assign search_xfer = in_valid && !in_stall && (in_data.func == FUNC_SEARCH);
    assign write_xfer  = in_valid && !in_stall && (in_data.func == FUNC_WRITE);

    // a stalled result holds
    `STBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // a search closes the input until its result is out
    `STBS_ASSERT_NEXT(a_search_busy, search_xfer, in_stall)

    // a write never produces a result
    `STBS_ASSERT_NEXT(a_write_silent, write_xfer && !out_valid, !out_valid)

    // a new result only appears at the end of a search
    `STBS_ASSERT_NOW(a_result_after_search, $rose(out_valid), $past(in_stall))

    // a miss always reports index zero
    `STBS_ASSERT_NOW(a_miss_index, out_valid && !out_data.hit, out_data.hit_index == '0)

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);

>>> test/search_result_checker.sv
// ----------------------------------------------------------------------------
// search_result_checker
// watches the three channels of the sorted table binary search block, keeps a
// mirror of the table and of entry_count, works out the answer of every
// search at its transfer and compares each result transfer with the oldest
// answer still owed
// ----------------------------------------------------------------------------
module search_result_checker
    import stbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  stbs_in_t           in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  stbs_out_t          out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    output int                 outstanding,
    output int                 failures
);
    timeunit 1ns;
    timeprecision 1ps;

    // mirror of the block state
    logic signed [VALUE_W-1:0] entry_mirror [TABLE_DEPTH];
    logic [COUNT_W-1:0]        count_mirror;

    // answers owed by the block, oldest first
    stbs_out_t                 owed_answers [$];
    int                        fail_cnt = 0;

    assign failures = fail_cnt;

    // binary search over the mirrored entries in use
    function automatic stbs_out_t predict_answer(input logic signed [VALUE_W-1:0] key);
        int        lo;
        int        hi;
        int        mid;
        stbs_out_t res;
        res = '0;
        lo  = 0;
        // count saturates at the table size
        hi  = ((count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror)) - 1;
        while (lo <= hi && !res.hit)
        begin
            mid = lo + (hi - lo) / 2;
            if (entry_mirror[mid] == key)
            begin
                res.hit       = 1'b1;
                res.hit_index = mid[INDEX_W-1:0];
            end
            else if (entry_mirror[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return res;
    endfunction

    // transfer monitor
    always @(posedge clk)
    begin
        stbs_out_t want;
        if (!rst_n)
        begin
            owed_answers.delete();
            count_mirror = '0;
            outstanding <= 0;
        end
        else
        begin
            // result transfer against the oldest answer
            if (out_valid && !out_stall)
            begin
                if (owed_answers.size() == 0)
                begin
                    $error("result transfer with no search outstanding");
                    fail_cnt++;
                end
                else
                begin
                    want = owed_answers.pop_front();
                    if (out_data.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, out_data.hit);
                        fail_cnt++;
                    end
                    if (out_data.hit_index !== want.hit_index)
                    begin
                        $error("hit_index: expected %0d, actual %0d",
                               want.hit_index, out_data.hit_index);
                        fail_cnt++;
                    end
                end
            end

            // input transfer updates the table or owes an answer
            if (in_valid && !in_stall)
            begin
                if (in_data.func == FUNC_WRITE)
                    entry_mirror[in_data.slot] = in_data.item_value;
                else
                    owed_answers.insert(owed_answers.size(),
                                        predict_answer(in_data.item_value));
            end

            // register write
            if (cfg_valid && cfg_ready)
                count_mirror = cfg_data;

            outstanding <= owed_answers.size();
        end
    end

endmodule

>>> test/sorted_table_binary_search_tb.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb
// stimulus for the sorted table binary search block: a directed opening with
// extreme values, duplicates, an unsorted table and small counts, then a full
// table load and random phases of table loads, count settings and searches,
// with random gaps on both channels; the checker judges every result
// ----------------------------------------------------------------------------
module sorted_table_binary_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int SETTLE       = 32;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1350;
    localparam int MIN_SEARCHES = 250;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    stbs_in_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    stbs_out_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data  = '0;

    int                 outstanding;
    int                 failures;

    // what the stimulus knows of the table, for choosing search keys
    logic signed [VALUE_W-1:0] written_values [TABLE_DEPTH];
    int                 cur_count     = 0;
    bit                 idle_on       = 1'b1;
    int                 items_sent    = 0;
    int                 searches_sent = 0;
    int                 cycles        = 0;

    always #4 clk = ~clk;

    sorted_table_binary_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    search_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .failures    (failures)
    );

    // one input transfer after a random gap
    task automatic send_item(input logic func, input int slot,
                             input logic signed [VALUE_W-1:0] value);
        stbs_in_t item;
        int       gap;
        item.func       = func;
        item.slot       = slot[SLOT_W-1:0];
        item.item_value = value;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        if (func == FUNC_WRITE)
            written_values[slot] = value;
        else
            searches_sent++;
        items_sent++;
    endtask

    // hold off until every result is in, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // entry_count write while the block is idle
    task automatic set_count(input int n);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= n[COUNT_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_count = n;
    endtask

    // write entries 0..n-1, ascending with duplicates or in random order
    task automatic load_prefix(input int n, input bit sorted, input int shift);
        logic [VALUE_W-1:0] offset;
        logic [VALUE_W-1:0] step;
        logic [VALUE_W-1:0] next;
        offset = {$urandom, $urandom} >> $urandom_range(shift, VALUE_W - 1);
        for (int i = 0; i < n; i++)
        begin
            if (sorted)
            begin
                // biased offset maps onto the signed range
                send_item(FUNC_WRITE, i, offset ^ VALUE_MIN);
                step = ($urandom_range(0, 5) == 0) ? '0 : ({$urandom, $urandom} >> shift);
                next = offset + step;
                offset = (next < offset) ? '1 : next;
            end
            else if ($urandom_range(0, 1))
                send_item(FUNC_WRITE, i, {$urandom, $urandom});
            else
                send_item(FUNC_WRITE, i, $urandom_range(0, 20));
        end
    endtask

    // search key: often an entry in use, some near misses, extremes, other slots and noise
    function automatic logic signed [VALUE_W-1:0] pick_key();
        int                        eff;
        int                        r;
        logic signed [VALUE_W-1:0] key;
        eff = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count;
        r   = $urandom_range(0, 99);
        if (eff > 0 && r < 45)
            key = written_values[$urandom_range(0, eff - 1)];
        else if (eff > 0 && r < 60)
            key = written_values[$urandom_range(0, eff - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        else if (r < 70)
            key = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
        else if (r < 85)
            key = written_values[$urandom_range(0, TABLE_DEPTH - 1)];
        else
            key = {$urandom, $urandom};
        return key;
    endfunction

    // searches with a few stray writes mixed in
    task automatic run_searches(input int k);
        for (int i = 0; i < k; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                send_item(FUNC_SEARCH, $urandom_range(0, TABLE_DEPTH - 1), pick_key());
            else
                send_item(FUNC_WRITE, $urandom_range(0, TABLE_DEPTH - 1), {$urandom, $urandom});
        end
    endtask

    // result side: random stall before each result transfer
    initial
    begin
        int gap;
        forever
        begin
            gap = idle_on ? $urandom_range(0, 10) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        int n;
        int r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count zero after reset: misses with no probe
        send_item(FUNC_SEARCH, 0, 0);
        send_item(FUNC_SEARCH, TABLE_DEPTH - 1, VALUE_MIN);

        // extremes of the value range, highest slot
        send_item(FUNC_WRITE, 0, VALUE_MIN);
        send_item(FUNC_WRITE, 1, -1);
        send_item(FUNC_WRITE, 2, 0);
        send_item(FUNC_WRITE, 3, 1);
        send_item(FUNC_WRITE, 4, VALUE_MAX);
        send_item(FUNC_WRITE, TABLE_DEPTH - 1, VALUE_MAX);
        set_count(5);
        send_item(FUNC_SEARCH, 0, VALUE_MIN);
        send_item(FUNC_SEARCH, 0, VALUE_MAX);
        send_item(FUNC_SEARCH, 0, 0);
        send_item(FUNC_SEARCH, 0, -1);
        send_item(FUNC_SEARCH, 0, 1);
        send_item(FUNC_SEARCH, 0, 5);
        send_item(FUNC_SEARCH, 0, -2);
        send_item(FUNC_SEARCH, 0, VALUE_MAX - 1);

        // duplicates: the first matching probe wins
        send_item(FUNC_WRITE, 1, 7);
        send_item(FUNC_WRITE, 2, 7);
        send_item(FUNC_WRITE, 3, 7);
        send_item(FUNC_SEARCH, 0, 7);

        // unsorted table: the probe walks past the only match
        send_item(FUNC_WRITE, 0, 100);
        send_item(FUNC_SEARCH, 0, 100);

        // single entry in use
        set_count(1);
        send_item(FUNC_SEARCH, 0, 100);

        // whole table, count above the table size, then at it
        items_sent    = 0;
        searches_sent = 0;
        load_prefix(TABLE_DEPTH, 1'b1, 10);
        set_count(2047);
        run_searches(60);
        set_count(TABLE_DEPTH);
        run_searches(40);

        // random phases: reload a prefix, set the count, search
        while (items_sent < RANDOM_ITEMS || searches_sent < MIN_SEARCHES)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                n = $urandom_range(1, 16);
            else if (r < 90)
                n = $urandom_range(17, 200);
            else if (r < 95)
                n = $urandom_range(0, 1);
            else
                n = $urandom_range(TABLE_DEPTH, 2047);
            idle_on = ($urandom_range(0, 3) != 0);
            if (n <= 200)
                load_prefix(n, $urandom_range(0, 4) != 0, $urandom_range(4, 62));
            set_count(n);
            run_searches($urandom_range(10, 30));
        end

        settle();
        if (failures == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sorted_table_binary_search.f
+incdir+rtl
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/stbs_probe.sv
rtl/sorted_table_binary_search.sv
rtl/stbs_checker.sv
test/search_result_checker.sv
test/sorted_table_binary_search_tb.sv
